[sv/mfd_pkg.sv]
// shared constants for the meter frame deframer
package mfd_pkg;
  localparam int MAX_PAYLOAD_DEF = 48;
  localparam int STORE_DEPTH_DEF = 64;
  localparam int HDR_LEN         = 11;
  localparam int IDX_W           = 6;
  localparam int CFG_IDX_W       = 1;

  localparam logic [7:0]  START_MARK = 8'h68;
  localparam logic [7:0]  END_MARK   = 8'h16;
  localparam logic [15:0] BROADCAST  = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_REGION   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_OWN_TERMINAL = 1'b1;
endpackage

[sv/meter_frame_deframer.sv]
// meter frame deframer: byte store, frame scan under a sequencer, result output
//
//   channel | signals                                     | direction
//   in      | in_valid_i, in_ready_o, rx_byte_i           | byte item in
//   out     | out_valid_o, out_ready_i, header/payload    | one item per payload byte, one if empty
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i/data  | register write
//
// a byte is taken in S_IDLE; the scan then reads the store through a single read port
// and one checksum adder: each pass starts in S_SCAN, each stored byte visited takes
// S_REQ then S_USE, the header is checked in S_CHK, and a new pass follows each drop.
// results are re-read from the store (S_REQ, S_USE, S_OUT) and wait for out_ready_i.
// in_ready_o is high only when the scan is finished and no result is pending.
// reset empties the store (head and count to zero); no clearing pass.
module meter_frame_deframer #(
  parameter int MAX_PAYLOAD = mfd_pkg::MAX_PAYLOAD_DEF,
  parameter int STORE_DEPTH = mfd_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [15:0]                   region_code_o,
  output logic [15:0]                   terminal_addr_o,
  output logic [5:0]                    station_id_o,
  output logic [6:0]                    frame_seq_o,
  output logic [2:0]                    inner_seq_o,
  output logic [5:0]                    control_code_o,
  output logic                          abnormal_o,
  output logic                          direction_o,
  output logic [5:0]                    payload_len_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          last_o,
  output logic                          address_match_o
);
  import mfd_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int SW = IDX_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_REQ  = 3'd2;
  localparam logic [2:0] S_USE  = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [2:0] PH_HDR  = 3'd0;
  localparam logic [2:0] PH_PAY  = 3'd1;
  localparam logic [2:0] PH_SUM  = 3'd2;
  localparam logic [2:0] PH_END  = 3'd3;
  localparam logic [2:0] PH_EMIT = 3'd4;

  logic [7:0]       mem_q [STORE_DEPTH];
  logic [7:0]       hdr_q [HDR_LEN];
  logic [2:0]       state_q, state_d;
  logic [2:0]       phase_q, phase_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CW-1:0]    count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [7:0]       sum_q, sum_d;
  logic [7:0]       rdata_q;
  logic [7:0]       pbyte_q, pbyte_d;
  logic             last_q, last_d;
  logic [15:0]      own_region_q, own_terminal_q;

  logic             in_acc, out_acc, hdr_we;
  logic [SW-1:0]    rd_sum, wr_sum, adv_sum;
  logic [AW-1:0]    rd_addr, wr_addr, adv_head;
  logic [IDX_W-1:0] adv_n;
  logic [5:0]       len;
  logic [IDX_W-1:0] last_idx;
  logic [CW:0]      total;
  logic             full, bad_hdr;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign full    = (count_q == CW'(STORE_DEPTH));
  assign len     = hdr_q[9][5:0];
  assign last_idx = IDX_W'(HDR_LEN - 1) + IDX_W'(len);
  assign total   = (CW + 1)'(HDR_LEN + 2) + (CW + 1)'(len);

  assign rd_sum  = SW'(head_q) + SW'(idx_q);
  assign rd_addr = (rd_sum >= SW'(STORE_DEPTH)) ? AW'(rd_sum - SW'(STORE_DEPTH)) : AW'(rd_sum);
  assign wr_sum  = full ? SW'(head_q) : SW'(head_q) + SW'(count_q);
  assign wr_addr = (wr_sum >= SW'(STORE_DEPTH)) ? AW'(wr_sum - SW'(STORE_DEPTH)) : AW'(wr_sum);
  assign adv_sum = SW'(head_q) + SW'(adv_n);
  assign adv_head = (adv_sum >= SW'(STORE_DEPTH)) ? AW'(adv_sum - SW'(STORE_DEPTH))
                                                  : AW'(adv_sum);

  assign bad_hdr = (hdr_q[0] != START_MARK) || (hdr_q[7] != START_MARK) ||
                   (hdr_q[10] != 8'd0) || (hdr_q[9] > 8'(MAX_PAYLOAD)) ||
                   (hdr_q[2] == 8'd1 && hdr_q[3] == 8'd0 && hdr_q[6] == END_MARK);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    pbyte_d = pbyte_q;
    last_d  = last_q;
    adv_n   = IDX_W'(1);
    hdr_we  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (full) begin
            head_d = adv_head;
          end else begin
            count_d = count_q + CW'(1);
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        idx_d   = '0;
        sum_d   = '0;
        phase_d = PH_HDR;
        state_d = (count_q < CW'(HDR_LEN)) ? S_IDLE : S_REQ;
      end
      S_REQ: begin
        state_d = S_USE;
      end
      S_USE: begin
        state_d = S_REQ;
        case (phase_q)
          PH_HDR: begin
            hdr_we = 1'b1;
            sum_d  = sum_q + rdata_q;
            if (idx_q == IDX_W'(HDR_LEN - 1)) begin
              state_d = S_CHK;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
          PH_PAY: begin
            sum_d = sum_q + rdata_q;
            if (idx_q == last_idx) begin
              phase_d = PH_SUM;
            end
            idx_d = idx_q + IDX_W'(1);
          end
          PH_SUM: begin
            if (rdata_q != sum_q) begin
              head_d  = adv_head;
              count_d = count_q - CW'(1);
              state_d = S_SCAN;
            end else begin
              idx_d   = idx_q + IDX_W'(1);
              phase_d = PH_END;
            end
          end
          PH_END: begin
            if (rdata_q != END_MARK) begin
              head_d  = adv_head;
              count_d = count_q - CW'(1);
              state_d = S_SCAN;
            end else begin
              idx_d   = IDX_W'(HDR_LEN);
              phase_d = PH_EMIT;
              if (len == 6'd0) begin
                pbyte_d = '0;
                last_d  = 1'b1;
                state_d = S_OUT;
              end
            end
          end
          PH_EMIT: begin
            pbyte_d = rdata_q;
            last_d  = (idx_q == last_idx);
            state_d = S_OUT;
          end
          default: state_d = S_SCAN;
        endcase
      end
      S_CHK: begin
        if (bad_hdr) begin
          head_d  = adv_head;
          count_d = count_q - CW'(1);
          state_d = S_SCAN;
        end else if ((CW + 1)'(count_q) < total) begin
          state_d = S_IDLE;
        end else begin
          idx_d   = IDX_W'(HDR_LEN);
          phase_d = (len == 6'd0) ? PH_SUM : PH_PAY;
          state_d = S_REQ;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (last_q) begin
            adv_n   = IDX_W'(total);
            head_d  = adv_head;
            count_d = count_q - CW'(total);
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = S_REQ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      phase_q        <= PH_HDR;
      head_q         <= '0;
      count_q        <= '0;
      own_region_q   <= '0;
      own_terminal_q <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_OWN_REGION:   own_region_q   <= cfg_data_i;
          REG_OWN_TERMINAL: own_terminal_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    sum_q   <= sum_d;
    pbyte_q <= pbyte_d;
    last_q  <= last_d;
    if (hdr_we) begin
      hdr_q[idx_q[3:0]] <= rdata_q;
    end
  end

  // byte store
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mem_q[wr_addr] <= rx_byte_i;
    end
    if (state_q == S_REQ) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign in_ready_o      = (state_q == S_IDLE);
  assign out_valid_o     = (state_q == S_OUT);
  assign region_code_o   = {hdr_q[2], hdr_q[1]};
  assign terminal_addr_o = {hdr_q[4], hdr_q[3]};
  assign station_id_o    = hdr_q[5][5:0];
  assign frame_seq_o     = {hdr_q[6][4:0], hdr_q[5][7:6]};
  assign inner_seq_o     = hdr_q[6][7:5];
  assign control_code_o  = hdr_q[8][5:0];
  assign abnormal_o      = hdr_q[8][6];
  assign direction_o     = hdr_q[8][7];
  assign payload_len_o   = len;
  assign payload_byte_o  = pbyte_q;
  assign last_o          = last_q;
  assign address_match_o =
      (region_code_o == BROADCAST && terminal_addr_o == BROADCAST) ||
      (region_code_o == own_region_q && terminal_addr_o == own_terminal_q);
endmodule

[sv/mfd_checker.sv]
// port checker for the meter frame deframer, with its bind
module mfd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [5:0]                    payload_len_o,
  input logic [7:0]                    payload_byte_o,
  input logic                          last_o
);
  a_busy_when_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input ready while item pending");

  a_more_after_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> !in_ready_o)
    else $error("input ready in the middle of a frame");

  a_empty_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && payload_len_o == 6'd0) |-> (last_o && payload_byte_o == 8'd0))
    else $error("empty payload item malformed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(payload_byte_o) &&
                                      $stable(last_o)))
    else $error("stalled item changed");
endmodule

bind meter_frame_deframer mfd_checker u_mfd_checker (.*);

[tb/testbench.sv]
// self-checking testbench for the meter frame deframer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import mfd_pkg::*;

  typedef struct packed {
    logic [15:0] region;
    logic [15:0] term;
    logic [5:0]  station;
    logic [6:0]  fseq;
    logic [2:0]  iseq;
    logic [5:0]  ctl;
    logic        abn;
    logic        dir;
    logic [5:0]  len;
    logic [7:0]  pay;
    logic        last;
    logic        match;
  } deframed_t;

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_END, FR_LONG, FR_LOOP} frame_kind_e;

  typedef struct {
    frame_kind_e kind;
    logic [15:0] region;
    logic [15:0] term;
    logic [15:0] word;
    logic [7:0]  ctl;
    int          len;
    int          exp_n;
    int          exp_match;
  } frame_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_OWN_REGION;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [7:0] rx_byte = '0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid;
  deframed_t got;

  meter_frame_deframer dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .rx_byte_i(rx_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .region_code_o(got.region), .terminal_addr_o(got.term), .station_id_o(got.station),
    .frame_seq_o(got.fseq), .inner_seq_o(got.iseq), .control_code_o(got.ctl),
    .abnormal_o(got.abn), .direction_o(got.dir), .payload_len_o(got.len),
    .payload_byte_o(got.pay), .last_o(got.last), .address_match_o(got.match)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [7:0]  rx_store [64];
  int          rx_head, rx_count;
  logic [15:0] my_region, my_term;
  deframed_t   deframed_q[$];
  int          predicted_frames, predicted_items, bytes_sent, errors, checked;
  int          snd_idle, rcv_idle;
  bit          hold_req;

  function automatic logic [7:0] peek_byte(int i);
    return rx_store[(rx_head + i) % 64];
  endfunction

  function automatic void drop_bytes(int n);
    if (n > rx_count) n = rx_count;
    rx_head = (rx_head + n) % 64;
    rx_count -= n;
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    int len, total, nres;
    logic [7:0] sum;
    logic [7:0] c;
    logic [15:0] w;
    deframed_t d;
    if (rx_count >= 64) drop_bytes(1);
    rx_store[(rx_head + rx_count) % 64] = b;
    rx_count++;
    forever begin
      if (rx_count < HDR_LEN) return;
      if (peek_byte(0) != START_MARK || peek_byte(7) != START_MARK) begin
        drop_bytes(1);
        continue;
      end
      len = {peek_byte(10), peek_byte(9)};
      if (len > MAX_PAYLOAD_DEF) begin
        drop_bytes(1);
        continue;
      end
      if (peek_byte(2) == 8'd1 && peek_byte(3) == 8'd0 && peek_byte(6) == END_MARK) begin
        drop_bytes(1);
        continue;
      end
      total = HDR_LEN + len + 2;
      if (rx_count < total) return;
      sum = '0;
      for (int i = 0; i < HDR_LEN + len; i++) sum += peek_byte(i);
      if (sum != peek_byte(HDR_LEN + len) || peek_byte(HDR_LEN + len + 1) != END_MARK) begin
        drop_bytes(1);
        continue;
      end
      break;
    end
    d.region = {peek_byte(2), peek_byte(1)};
    d.term = {peek_byte(4), peek_byte(3)};
    w = {peek_byte(6), peek_byte(5)};
    d.station = w[5:0];
    d.fseq = w[12:6];
    d.iseq = w[15:13];
    c = peek_byte(8);
    d.ctl = c[5:0];
    d.abn = c[6];
    d.dir = c[7];
    d.len = len[5:0];
    d.match = (d.region == BROADCAST && d.term == BROADCAST) ||
              (d.region == my_region && d.term == my_term);
    nres = (len == 0) ? 1 : len;
    for (int k = 0; k < nres; k++) begin
      d.pay = (len == 0) ? 8'h00 : peek_byte(HDR_LEN + k);
      d.last = (k + 1 == nres);
      deframed_q.push_back(d);
    end
    predicted_frames++;
    predicted_items += nres;
    drop_bytes(total);
  endfunction

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(frame_row_t r, int noise);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [15:0] lenf;
    int plen;
    for (int i = 0; i < noise; i++) fb.push_back(8'($urandom_range(255)));
    lenf = 16'(r.len);
    plen = (r.kind == FR_LONG) ? $urandom_range(0, 4) : r.len;
    fb.push_back(START_MARK);
    fb.push_back(r.region[7:0]);
    fb.push_back(r.kind == FR_LOOP ? 8'd1 : r.region[15:8]);
    fb.push_back(r.kind == FR_LOOP ? 8'd0 : r.term[7:0]);
    fb.push_back(r.term[15:8]);
    fb.push_back(r.word[7:0]);
    fb.push_back(r.kind == FR_LOOP ? END_MARK : r.word[15:8]);
    fb.push_back(START_MARK);
    fb.push_back(r.ctl);
    fb.push_back(lenf[7:0]);
    fb.push_back(lenf[15:8]);
    for (int k = 0; k < plen; k++)
      fb.push_back(r.exp_n >= 0 ? (k == 0 ? 8'hFF : 8'(k * 37 + 1)) : 8'($urandom_range(255)));
    sum = '0;
    foreach (fb[i]) if (i >= noise) sum += fb[i];
    fb.push_back(r.kind == FR_BAD_SUM ? sum + 8'd1 : sum);
    fb.push_back(r.kind == FR_BAD_END ? 8'h00 : END_MARK);
    foreach (fb[i]) send_byte(fb[i]);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OWN_REGION) my_region = val;
    else my_term = val;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (deframed_q.size() != 0);
    repeat (4) @(posedge clk);
    while (!in_ready) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic frame_row_t random_frame();
    frame_row_t r;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      r.region = my_region;
      r.term = my_term;
    end else if (pick < 60) begin
      r.region = BROADCAST;
      r.term = BROADCAST;
    end else if (pick < 70) begin
      r.region = my_region ^ (16'd1 << $urandom_range(15));
      r.term = my_term;
    end else begin
      r.region = 16'($urandom_range(65535));
      r.term = 16'($urandom_range(65535));
    end
    r.word = 16'($urandom_range(65535));
    r.ctl = 8'($urandom_range(255));
    pick = $urandom_range(99);
    r.len = (pick < 80) ? $urandom_range(0, 6) : (pick < 95) ? $urandom_range(7, 20) : 48;
    pick = $urandom_range(99);
    r.kind = (pick < 72) ? FR_GOOD : (pick < 79) ? FR_BAD_SUM : (pick < 86) ? FR_BAD_END :
             (pick < 93) ? FR_LOOP : FR_LONG;
    if (r.kind == FR_LONG) r.len = $urandom_range(49, 65535);
    r.exp_n = -1;
    r.exp_match = -1;
    return r;
  endfunction

  // receiver with random stalls and one long hold-off
  int hold_left = 0;
  always @(posedge clk) begin
    deframed_t want;
    if (out_valid && out_ready) begin
      checked++;
      if (deframed_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item %h", got);
      end else begin
        want = deframed_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
    if (hold_req) begin
      hold_left = 400;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  frame_row_t directed [8] = '{
    '{FR_GOOD,    16'hFFFF, 16'hFFFF, 16'h0000, 8'h00, 0,  1,  1},
    '{FR_GOOD,    16'h0000, 16'h0000, 16'hFFFF, 8'hFF, 2,  2,  1},
    '{FR_GOOD,    16'h1234, 16'h5678, 16'hA5C3, 8'h41, 1,  1,  0},
    '{FR_BAD_SUM, 16'h0000, 16'h0000, 16'h0001, 8'h02, 1,  0, -1},
    '{FR_BAD_END, 16'h0000, 16'h0000, 16'h0002, 8'h03, 1,  0, -1},
    '{FR_LONG,    16'h0000, 16'h0000, 16'h0003, 8'h04, 49, 0, -1},
    '{FR_LOOP,    16'h0000, 16'h0000, 16'h0004, 8'h05, 0,  0, -1},
    '{FR_GOOD,    16'hFFFF, 16'hFFFF, 16'h8000, 8'h80, 3, -1, -1}
  };

  logic [15:0] cfg_sets [4][2] = '{'{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF},
                                   '{16'h1234, 16'hABCD}, '{16'h0001, 16'h8000}};

  initial begin
    int before_n;
    int ph_start;
    snd_idle = 9;
    rcv_idle = 64;
    hold_req = 1'b0;
    my_region = '0;
    my_term = '0;
    rx_head = 0;
    rx_count = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      before_n = predicted_items;
      send_frame(directed[i], 0);
      if (directed[i].exp_n >= 0 && predicted_items - before_n != directed[i].exp_n) begin
        errors++;
        $display("row %0d: %0d items predicted, %0d typed", i,
                 predicted_items - before_n, directed[i].exp_n);
      end
      if (directed[i].exp_match >= 0 && directed[i].exp_n > 0 &&
          deframed_q[$].match != directed[i].exp_match) begin
        errors++;
        $display("row %0d: address match differs from typed value", i);
      end
    end
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin snd_idle = 9;  rcv_idle = 64; end
        1: begin snd_idle = 64; rcv_idle = 9;  end
        default: begin snd_idle = 0; rcv_idle = 0; end
      endcase
      if (ph < 4) begin
        write_reg(REG_OWN_REGION, cfg_sets[ph][0]);
        write_reg(REG_OWN_TERMINAL, cfg_sets[ph][1]);
      end else begin
        write_reg(REG_OWN_TERMINAL, 16'($urandom_range(65535)));
        write_reg(REG_OWN_REGION, 16'($urandom_range(65535)));
      end
      ph_start = bytes_sent;
      if (ph == 2) begin
        frame_row_t big;
        big = random_frame();
        big.kind = FR_GOOD;
        big.len = 20;
        send_frame(big, 0);
        hold_req = 1'b1;
        send_frame(big, 0);
      end
      while (bytes_sent < ph_start + 32)
        send_frame(random_frame(), ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
      wait_idle();
    end

    $display("%0d bytes sent, %0d frames deframed, %0d items checked over 6 address settings",
             bytes_sent, predicted_frames, checked);
    if (errors == 0 && deframed_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d errors, %0d items still expected", errors, deframed_q.size());
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("testbench failed");
    $finish;
  end
endmodule
